// ----- rtl/core/sls_pkg.sv -----
// Shared types, sizes, request and status codes for the segmented list store.
// Used by sls_ctrl, sls_dpath and the top level segmented_list_store.
package sls_pkg;

  // Store geometry and element width.
  localparam int NUM_LISTS     = 8;
  localparam int LIST_CAPACITY = 16;
  localparam int HANDLE_WIDTH  = 32;

  localparam int STORE_DEPTH = NUM_LISTS * LIST_CAPACITY;
  localparam int LIST_W      = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CNT_W       = $clog2(LIST_CAPACITY + 1);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
  localparam int BL_W        = $clog2(NUM_LISTS + 1);

  // Request codes.
  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_INS  = 3'd1;
  localparam logic [2:0] FN_REM  = 3'd2;
  localparam logic [2:0] FN_BAL  = 3'd3;
  localparam logic [2:0] FN_READ = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_POS   = 2'd3;

  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [LIST_W-1:0]       list_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_DECIDE,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_PUT,
    CMD_DEC,
    CMD_RD,
    CMD_RD_CAP,
    CMD_BAL_INIT,
    CMD_BAL_RD,
    CMD_BAL_WT,
    CMD_BAL_NEXT,
    CMD_BAL_TGT,
    CMD_BAL_TRD,
    CMD_BAL_WR,
    CMD_BAL_CNT,
    CMD_PUBLISH
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       err;
    logic [2:0] func;
    logic       more;
    logic       scan_end;
    logic       scan_has;
    logic       out_end;
  } dp_stat_t;

  // Flat store address of a slot within a list.
  function automatic addr_t addr_of(input list_t l, input count_t s);
    return ADDR_W'(int'(l) * LIST_CAPACITY + int'(s));
  endfunction

  // Port handle to stored handle width.
  function automatic handle_t hdl_in(input logic [31:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[HANDLE_WIDTH-1:0];
  endfunction

  // Stored handle to port width.
  function automatic logic [31:0] hdl_out(input handle_t h);
    logic [63:0] w;
    w = 64'(h);
    return w[31:0];
  endfunction

endpackage

// ----- rtl/core/sls_ctrl.sv -----
// Controller state machine of the segmented list store.
// Depends on sls_pkg for command and status types.
module sls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sls_pkg::dp_stat_t stat,
  output sls_pkg::cmd_t     cmd
);
  import sls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_BRANCH,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DEC,
    S_RD,
    S_RD_CAP,
    S_BAL_SCAN,
    S_BAL_WT,
    S_BAL_TGT,
    S_BAL_OUT,
    S_BAL_WR,
    S_BAL_CNT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   publish;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign publish   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Next state and the command issued in the current state.
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd       = CMD_DECIDE;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (stat.err) begin
          state_nxt = S_FINISH;
        end else begin
          case (stat.func)
            FN_ADD, FN_INS: state_nxt = stat.more ? S_SH_RD : S_PUT;
            FN_REM:         state_nxt = stat.more ? S_SH_RD : S_DEC;
            FN_READ:        state_nxt = S_RD;
            FN_BAL: begin
              cmd       = CMD_BAL_INIT;
              state_nxt = S_BAL_SCAN;
            end
            default:        state_nxt = S_FINISH;
          endcase
        end
      end
      S_SH_RD: begin
        cmd       = CMD_SH_RD;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd       = CMD_SH_WR;
        state_nxt = S_BRANCH;
      end
      S_PUT: begin
        cmd       = CMD_PUT;
        state_nxt = S_FINISH;
      end
      S_DEC: begin
        cmd       = CMD_DEC;
        state_nxt = S_FINISH;
      end
      S_RD: begin
        cmd       = CMD_RD;
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd       = CMD_RD_CAP;
        state_nxt = S_FINISH;
      end
      S_BAL_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_BAL_TGT;
        end else if (stat.scan_has) begin
          cmd       = CMD_BAL_RD;
          state_nxt = S_BAL_WT;
        end else begin
          cmd = CMD_BAL_NEXT;
        end
      end
      S_BAL_WT: begin
        cmd       = CMD_BAL_WT;
        state_nxt = S_BAL_SCAN;
      end
      S_BAL_TGT: begin
        cmd       = CMD_BAL_TGT;
        state_nxt = S_BAL_OUT;
      end
      S_BAL_OUT: begin
        if (stat.out_end) begin
          state_nxt = S_BAL_CNT;
        end else begin
          cmd       = CMD_BAL_TRD;
          state_nxt = S_BAL_WR;
        end
      end
      S_BAL_WR: begin
        cmd       = CMD_BAL_WR;
        state_nxt = S_BAL_OUT;
      end
      S_BAL_CNT: begin
        cmd       = CMD_BAL_CNT;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (publish) begin
          cmd       = CMD_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result register is loaded on publish and freed when taken.
  always_comb begin
    if (publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/sls_dpath.sv -----
// Datapath of the segmented list store: element memory, balance buffer,
// list counts, request registers and result registers. Depends on sls_pkg.
module sls_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  sls_pkg::cmd_t     cmd,
  input  logic [2:0]        in_func,
  input  logic [3:0]        in_list_sel,
  input  logic [4:0]        in_slot,
  input  logic [31:0]       in_item_handle,
  output sls_pkg::dp_stat_t stat,
  output logic [1:0]        out_status,
  output logic [31:0]       out_read_handle,
  output logic [2:0]        out_placed_list,
  output logic [3:0]        out_placed_slot
);
  import sls_pkg::*;

  // Element store and the balance buffer.
  handle_t store_mem [STORE_DEPTH];
  handle_t tmp_mem   [STORE_DEPTH];
  handle_t q_r, tq_r;

  count_t cnt_r [NUM_LISTS];

  // Request and working registers.
  logic [2:0]      func_r;
  logic [3:0]      sel_r;
  logic [4:0]      slot_r;
  handle_t         hdl_r;
  logic [1:0]      status_r;
  logic            place_r;
  logic [31:0]     rd_r;
  list_t           tgt_r;
  count_t          pos_r, idx_r, n_r;
  logic [BL_W-1:0] bl_r;
  count_t          bs_r;
  logic [TOT_W-1:0] tot_r, gi_r;
  count_t          tgtc_r;
  list_t           ol_r;
  count_t          os_r;

  // Result registers.
  logic [1:0]  o_status_r;
  logic [31:0] o_rd_r;
  logic [2:0]  o_pl_r;
  logic [3:0]  o_ps_r;

  // Request check and target selection.
  logic       sel_ok;
  list_t      sel_idx;
  count_t     sel_cnt;
  logic       first_found, after_found;
  list_t      first_idx, after_idx;
  logic [1:0] dec_status;
  list_t      dec_tgt;
  count_t     dec_pos;
  logic       dec_place;
  list_t      bl_idx;

  assign sel_ok  = ({1'b0, sel_r} < 5'(NUM_LISTS));
  assign sel_idx = LIST_W'(sel_r);
  assign sel_cnt = sel_ok ? cnt_r[sel_idx] : '0;
  assign bl_idx  = LIST_W'(bl_r);

  // Lowest non-full list overall and lowest one above the chosen list.
  always_comb begin
    first_found = 1'b0;
    after_found = 1'b0;
    first_idx   = '0;
    after_idx   = '0;
    for (int i = NUM_LISTS - 1; i >= 0; i--) begin
      if (cnt_r[i] < count_t'(LIST_CAPACITY)) begin
        first_found = 1'b1;
        first_idx   = LIST_W'(i);
        if (i > int'(sel_r)) begin
          after_found = 1'b1;
          after_idx   = LIST_W'(i);
        end
      end
    end
  end

  always_comb begin
    dec_status = ST_OK;
    dec_tgt    = first_idx;
    dec_pos    = '0;
    dec_place  = 1'b0;
    case (func_r)
      FN_ADD: begin
        if (first_found) begin
          dec_pos   = cnt_r[first_idx];
          dec_place = 1'b1;
        end else begin
          dec_status = ST_FULL;
        end
      end
      FN_INS: begin
        if (!sel_ok) begin
          dec_status = ST_RANGE;
        end else if (sel_cnt >= count_t'(LIST_CAPACITY)) begin
          // Chosen list full: go to the front of the next list with room.
          if (after_found) begin
            dec_tgt   = after_idx;
            dec_place = 1'b1;
          end else begin
            dec_status = ST_FULL;
          end
        end else if (int'(slot_r) > int'(sel_cnt)) begin
          dec_status = ST_POS;
        end else begin
          dec_tgt   = sel_idx;
          dec_pos   = count_t'(slot_r);
          dec_place = 1'b1;
        end
      end
      FN_REM, FN_READ: begin
        if (!sel_ok) begin
          dec_status = ST_RANGE;
        end else if (int'(slot_r) >= int'(sel_cnt)) begin
          dec_status = ST_POS;
        end else begin
          dec_tgt = sel_idx;
          dec_pos = count_t'(slot_r);
        end
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.err      = (status_r != ST_OK);
    stat.func     = func_r;
    stat.more     = (func_r == FN_REM) ? (int'(idx_r) + 1 < int'(n_r)) : (idx_r > pos_r);
    stat.scan_end = (int'(bl_r) >= NUM_LISTS);
    stat.scan_has = !stat.scan_end && (bs_r < cnt_r[bl_idx]);
    stat.out_end  = (gi_r == tot_r);
  end

  // Memory port selection.
  logic    we, re, twe, tre;
  addr_t   wa, ra;
  handle_t wd;

  always_comb begin
    we  = 1'b0;
    re  = 1'b0;
    twe = (cmd == CMD_BAL_WT);
    tre = (cmd == CMD_BAL_TRD);
    wa  = addr_of(tgt_r, idx_r);
    ra  = addr_of(tgt_r, pos_r);
    wd  = q_r;
    case (cmd)
      CMD_SH_RD: begin
        re = 1'b1;
        ra = addr_of(tgt_r, (func_r == FN_REM) ? idx_r + 1'b1 : idx_r - 1'b1);
      end
      CMD_SH_WR: we = 1'b1;
      CMD_PUT: begin
        we = 1'b1;
        wa = addr_of(tgt_r, pos_r);
        wd = hdl_r;
      end
      CMD_RD:     re = 1'b1;
      CMD_BAL_RD: begin
        re = 1'b1;
        ra = addr_of(bl_idx, bs_r);
      end
      CMD_BAL_WR: begin
        we = 1'b1;
        wa = addr_of(ol_r, os_r);
        wd = tq_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[wa] <= wd;
    end
    if (re) begin
      q_r <= store_mem[ra];
    end
    if (twe) begin
      tmp_mem[ADDR_W'(tot_r)] <= q_r;
    end
    if (tre) begin
      tq_r <= tmp_mem[ADDR_W'(gi_r)];
    end
  end

  // List lengths after a balance pass.
  count_t bal_cnt [NUM_LISTS];
  always_comb begin
    int base;
    int remn;
    for (int i = 0; i < NUM_LISTS; i++) begin
      base = i * int'(tgtc_r);
      remn = int'(tot_r) - base;
      if (remn <= 0) begin
        bal_cnt[i] = '0;
      end else if (remn >= int'(tgtc_r)) begin
        bal_cnt[i] = tgtc_r;
      end else begin
        bal_cnt[i] = CNT_W'(remn);
      end
    end
  end

  // List counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      case (cmd)
        CMD_PUT: cnt_r[tgt_r] <= cnt_r[tgt_r] + 1'b1;
        CMD_DEC: cnt_r[tgt_r] <= cnt_r[tgt_r] - 1'b1;
        CMD_BAL_CNT: begin
          for (int i = 0; i < NUM_LISTS; i++) begin
            cnt_r[i] <= bal_cnt[i];
          end
        end
        default: ;
      endcase
    end
  end

  // Request, loop and result registers.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        func_r <= in_func;
        sel_r  <= in_list_sel;
        slot_r <= in_slot;
        hdl_r  <= hdl_in(in_item_handle);
      end
      CMD_DECIDE: begin
        status_r <= dec_status;
        place_r  <= dec_place;
        tgt_r    <= dec_tgt;
        pos_r    <= dec_pos;
        n_r      <= cnt_r[dec_tgt];
        idx_r    <= (func_r == FN_REM) ? dec_pos : cnt_r[dec_tgt];
        rd_r     <= '0;
      end
      CMD_SH_WR: idx_r <= (func_r == FN_REM) ? idx_r + 1'b1 : idx_r - 1'b1;
      CMD_RD_CAP: rd_r <= hdl_out(q_r);
      CMD_BAL_INIT: begin
        bl_r  <= '0;
        bs_r  <= '0;
        tot_r <= '0;
      end
      CMD_BAL_WT: begin
        tot_r <= tot_r + 1'b1;
        bs_r  <= bs_r + 1'b1;
      end
      CMD_BAL_NEXT: begin
        bl_r <= bl_r + 1'b1;
        bs_r <= '0;
      end
      CMD_BAL_TGT: begin
        tgtc_r <= CNT_W'((int'(tot_r) + NUM_LISTS - 1) / NUM_LISTS);
        gi_r   <= '0;
        ol_r   <= '0;
        os_r   <= '0;
      end
      CMD_BAL_WR: begin
        gi_r <= gi_r + 1'b1;
        if (count_t'(os_r + 1'b1) == tgtc_r) begin
          ol_r <= ol_r + 1'b1;
          os_r <= '0;
        end else begin
          os_r <= os_r + 1'b1;
        end
      end
      CMD_PUBLISH: begin
        o_status_r <= status_r;
        o_rd_r     <= rd_r;
        o_pl_r     <= place_r ? 3'(tgt_r) : 3'd0;
        o_ps_r     <= place_r ? 4'(pos_r) : 4'd0;
      end
      default: ;
    endcase
  end

  assign out_status      = o_status_r;
  assign out_read_handle = o_rd_r;
  assign out_placed_list = o_pl_r;
  assign out_placed_slot = o_ps_r;

endmodule

// ----- rtl/core/segmented_list_store.sv -----
// Top level of the segmented list store: controller plus datapath.
// Depends on sls_pkg, sls_ctrl and sls_dpath.

// Keeps eight lists of up to sixteen handles in one single-port-style
// element memory and serves one request at a time; a result stays in its
// output register until taken, while the next request is already accepted.
// Insert and remove take longer with each shifted entry, and balance with each
// list and each stored entry, since every entry is copied out to a buffer
// memory and back.
module segmented_list_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_list_sel,
  input  logic [4:0]  in_slot,
  input  logic [31:0] in_item_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_handle,
  output logic [2:0]  out_placed_list,
  output logic [3:0]  out_placed_slot
);
  import sls_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  sls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sls_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_list_sel     (in_list_sel),
    .in_slot         (in_slot),
    .in_item_handle  (in_item_handle),
    .stat            (stat),
    .out_status      (out_status),
    .out_read_handle (out_read_handle),
    .out_placed_list (out_placed_list),
    .out_placed_slot (out_placed_slot)
  );

`ifndef SYNTH
  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // A failed request places nothing and reads nothing.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_placed_list == 3'd0) && (out_placed_slot == 4'd0) && (out_read_handle == 32'd0))
    else $error("error result carries placement or read data");

  // A new result appears only as the controller returns to idle.
  a_pub_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result published outside the return to idle");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for segmented_list_store: directed table, then random requests.
// Depends on sls_pkg and the segmented_list_store RTL; predicts every result in-line.
module tb_top;
  import sls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [3:0]  in_list_sel;
  logic [4:0]  in_slot;
  logic [31:0] in_item_handle;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_read_handle;
  logic [2:0]  out_placed_list;
  logic [3:0]  out_placed_slot;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rd;
    logic [2:0]  plist;
    logic [3:0]  pslot;
  } answer_t;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  sel;
    logic [4:0]  slot;
    logic [31:0] hdl;
    bit          typed;
    answer_t     ans;
  } row_t;

  // Mirror of the lists kept by the predictor.
  logic [31:0] mirror_mem [NUM_LISTS][LIST_CAPACITY];
  int          mirror_cnt [NUM_LISTS];

  answer_t answer_q [$];
  int      fail_count;
  int      idle_cycles;
  bit      hold_recv;

  segmented_list_store u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Insert a handle at a position of a mirrored list.
  task automatic mirror_put(input int l, input int p, input logic [31:0] h);
    int k;
    for (k = mirror_cnt[l]; k > p; k--) mirror_mem[l][k] = mirror_mem[l][k-1];
    mirror_mem[l][p] = h;
    mirror_cnt[l]++;
  endtask

  // Work out the answer to one request and update the mirror.
  task automatic predict_answer(input logic [2:0] f, input logic [3:0] sel,
                                input logic [4:0] slot, input logic [31:0] h,
                                output answer_t a);
    logic [31:0] flat [$];
    int i, j, tgt, idx;
    a = '0;
    case (f)
      FN_ADD: begin
        a.status = ST_FULL;
        for (i = 0; i < NUM_LISTS; i++) begin
          if (mirror_cnt[i] < LIST_CAPACITY) begin
            a.plist = 3'(i);
            a.pslot = 4'(mirror_cnt[i]);
            mirror_put(i, mirror_cnt[i], h);
            a.status = ST_OK;
            break;
          end
        end
      end
      FN_INS: begin
        if (sel >= NUM_LISTS) a.status = ST_RANGE;
        else if (mirror_cnt[sel] >= LIST_CAPACITY) begin
          a.status = ST_FULL;
          for (i = sel + 1; i < NUM_LISTS; i++) begin
            if (mirror_cnt[i] < LIST_CAPACITY) begin
              mirror_put(i, 0, h);
              a.plist = 3'(i);
              a.status = ST_OK;
              break;
            end
          end
        end else if (slot > mirror_cnt[sel]) a.status = ST_POS;
        else begin
          mirror_put(sel, slot, h);
          a.plist = 3'(sel);
          a.pslot = 4'(slot);
        end
      end
      FN_REM: begin
        if (sel >= NUM_LISTS) a.status = ST_RANGE;
        else if (slot >= mirror_cnt[sel]) a.status = ST_POS;
        else begin
          for (i = slot; i + 1 < mirror_cnt[sel]; i++)
            mirror_mem[sel][i] = mirror_mem[sel][i+1];
          mirror_cnt[sel]--;
        end
      end
      FN_BAL: begin
        for (i = 0; i < NUM_LISTS; i++)
          for (j = 0; j < mirror_cnt[i]; j++) flat.push_back(mirror_mem[i][j]);
        tgt = (flat.size() + NUM_LISTS - 1) / NUM_LISTS;
        idx = 0;
        for (i = 0; i < NUM_LISTS; i++) begin
          for (j = 0; j < tgt && idx < flat.size(); j++) mirror_mem[i][j] = flat[idx++];
          mirror_cnt[i] = j;
        end
      end
      FN_READ: begin
        if (sel >= NUM_LISTS) a.status = ST_RANGE;
        else if (slot >= mirror_cnt[sel]) a.status = ST_POS;
        else a.rd = mirror_mem[sel][slot];
      end
      default: ;
    endcase
  endtask

  // Offer one item after a random gap and wait until it is accepted.
  task automatic send_item(input logic [2:0] f, input logic [3:0] sel,
                           input logic [4:0] slot, input logic [31:0] h,
                           input bit typed, input answer_t ta);
    int gap;
    answer_t a;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_func = f;
    in_list_sel = sel;
    in_slot = slot;
    in_item_handle = h;
    do @(posedge clk); while (!in_ready);
    predict_answer(f, sel, slot, h, a);
    if (typed && a !== ta) begin
      $display("%0t table row disagrees with predictor: table %h predictor %h",
               $time, ta, a);
      fail_count++;
    end
    answer_q.push_back(typed ? ta : a);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random request mostly aimed at valid lists and positions.
  task automatic send_random();
    logic [2:0]  f;
    logic [3:0]  sel;
    logic [4:0]  slot;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 30) f = FN_ADD;
    else if (r < 50) f = FN_INS;
    else if (r < 72) f = FN_REM;
    else if (r < 75) f = FN_BAL;
    else if (r < 97) f = FN_READ;
    else f = 3'($urandom_range(5, 7));
    sel = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                         : $urandom_range(0, NUM_LISTS - 1));
    if (sel < NUM_LISTS && $urandom_range(0, 9) != 0)
      slot = 5'($urandom_range(0, mirror_cnt[sel]));
    else slot = 5'($urandom_range(0, 31));
    send_item(f, sel, slot, $urandom(), 1'b0, '0);
  endtask

  // Wait until every expected result has come back.
  task automatic wait_drained();
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int gap;
    bit held_once;
    held_once = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_recv && !held_once) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        held_once = 1'b1;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      out_ready = 1'b0;
      repeat (gap) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t unexpected result: status %0d handle %h", $time, out_status,
                 out_read_handle);
        fail_count++;
      end else begin
        exp_a = answer_q.pop_front();
        if (out_status !== exp_a.status || out_read_handle !== exp_a.rd ||
            out_placed_list !== exp_a.plist || out_placed_slot !== exp_a.pslot) begin
          $display("%0t mismatch: expected st %0d rd %h pl %0d ps %0d, got st %0d rd %h pl %0d ps %0d",
                   $time, exp_a.status, exp_a.rd, exp_a.plist, exp_a.pslot,
                   out_status, out_read_handle, out_placed_list, out_placed_slot);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed table, random phase, pressure phases and the end of the run.
  initial begin
    row_t    tbl [$];
    row_t    rw;
    int      n, l;
    fail_count = 0;
    hold_recv = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_list_sel = '0;
    in_slot = '0;
    in_item_handle = '0;
    for (l = 0; l < NUM_LISTS; l++) mirror_cnt[l] = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: typed answers after reset, at extremes and for errors.
    tbl.push_back('{FN_READ, 4'd0, 5'd0, 32'h0, 1'b1, '{ST_POS, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_REM, 4'd7, 5'd0, 32'h0, 1'b1, '{ST_POS, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_BAL, 4'd0, 5'd0, 32'h0, 1'b1, '{ST_OK, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_ADD, 4'd0, 5'd0, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_READ, 4'd0, 5'd0, 32'h0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 3'd0, 4'd0}});
    tbl.push_back('{FN_INS, 4'd15, 5'd0, 32'h1, 1'b1, '{ST_RANGE, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_REM, 4'd8, 5'd0, 32'h0, 1'b1, '{ST_RANGE, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_READ, 4'd9, 5'd0, 32'h0, 1'b1, '{ST_RANGE, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_INS, 4'd0, 5'd31, 32'h2, 1'b1, '{ST_POS, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_INS, 4'd0, 5'd0, 32'h0, 1'b1, '{ST_OK, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_INS, 4'd7, 5'd0, 32'hA5A5A5A5, 1'b1, '{ST_OK, 32'h0, 3'd7, 4'd0}});
    tbl.push_back('{FN_READ, 4'd0, 5'd1, 32'h0, 1'b0, '{default: '0}});
    tbl.push_back('{3'd5, 4'd3, 5'd3, 32'h5A5A5A5A, 1'b1, '{ST_OK, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{3'd7, 4'd15, 5'd31, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 3'd0, 4'd0}});
    tbl.push_back('{FN_BAL, 4'd0, 5'd0, 32'h0, 1'b0, '{default: '0}});
    tbl.push_back('{FN_REM, 4'd0, 5'd0, 32'h0, 1'b0, '{default: '0}});
    tbl.push_back('{FN_READ, 4'd0, 5'd31, 32'h0, 1'b1, '{ST_POS, 32'h0, 3'd0, 4'd0}});
    foreach (tbl[i]) begin
      rw = tbl[i];
      send_item(rw.func, rw.sel, rw.slot, rw.hdl, rw.typed, rw.ans);
    end

    // Fill every list, then probe the full cases.
    for (n = 0; n < STORE_DEPTH; n++) send_item(FN_ADD, 4'd0, 5'd0, $urandom(), 1'b0, '0);
    send_item(FN_ADD, 4'd0, 5'd0, 32'h1234, 1'b1, '{ST_FULL, 32'h0, 3'd0, 4'd0});
    send_item(FN_INS, 4'd2, 5'd16, 32'h1234, 1'b1, '{ST_FULL, 32'h0, 3'd0, 4'd0});
    send_item(FN_REM, 4'd5, 5'd15, 32'h0, 1'b0, '0);
    send_item(FN_INS, 4'd1, 5'd3, 32'hCAFE, 1'b1, '{ST_OK, 32'h0, 3'd5, 4'd0});
    send_item(FN_READ, 4'd7, 5'd15, 32'h0, 1'b0, '0);

    // Receiver holds off while the sender keeps offering items.
    hold_recv = 1'b1;
    for (n = 0; n < 20; n++) send_random();
    // Sender pauses until everything is back.
    wait_drained();
    for (n = 0; n < 40; n++) send_item(FN_REM, 4'($urandom_range(0, 7)), 5'd0, 32'h0, 1'b0, '0);
    send_item(FN_BAL, 4'd0, 5'd0, 32'h0, 1'b0, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) send_random();

    wait_drained();
    repeat (600) @(negedge clk);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
